// ===== rtl/rpb_pkg.sv =====
// Package for the RGB palette builder: palette sizing, function codes,
// item and result structs, the search token and the control state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpb_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int KEY_W = (IDX_W > 8) ? IDX_W : 8;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] read_index;
    } rpb_in_t;

    typedef struct packed {
        logic [7:0] entry_index;
        logic       was_new;
        logic       overflow;
        logic [8:0] palette_count;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
    } rpb_out_t;

    // Search token that walks the cell row, one cell per clock.
    typedef struct packed {
        logic             valid;
        logic             is_read;
        logic [23:0]      color;
        logic [7:0]       read_index;
        logic             hit;
        logic [IDX_W-1:0] hit_index;
        logic [23:0]      rd_color;
    } tok_t;

    // Broadcast write of a new palette entry.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        logic [23:0]      color;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rpb_cell.sv =====
// One palette cell: holds a single 24-bit entry and passes the search token
// on to its neighbor every clock. Depends on rpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpb_cell
    import rpb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire logic [CNT_W-1:0] count,
    input  wire wr_t              wr,
    input  wire tok_t             tok_in,
    output tok_t                  tok_out
);

    logic [23:0] entry_reg;
    logic        tok_valid_reg;
    logic        tok_valid_next;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        in_range;
    logic        read_match;

    assign in_range   = CNT_W'(cell_index) < count;
    assign read_match = KEY_W'(tok_in.read_index) == KEY_W'(cell_index);

    always_comb
    begin
        tok_next = tok_in;
        tok_valid_next = tok_in.valid;
        if (tok_in.valid && in_range)
        begin
            // Stored colors are distinct, so at most one cell can hit.
            if (tok_in.is_read)
            begin
                if (read_match)
                begin
                    tok_next.hit = 1'b1;
                    tok_next.rd_color = entry_reg;
                end
            end
            else if (tok_in.color == entry_reg)
            begin
                tok_next.hit = 1'b1;
                tok_next.hit_index = cell_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr.en && wr.index == cell_index)
        begin
            entry_reg <= wr.color;
        end
    end

    always_comb
    begin
        tok_out = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/rgb_palette_builder.sv =====
// Top level of the RGB palette builder: control, status registers and the
// row of palette cells. Depends on rpb_pkg and rpb_cell.
`timescale 1ns / 1ps
`default_nettype none

// The palette lives in a row of PALETTE_DEPTH cells, one entry per cell. A
// pixel or read item enters the first cell as a token and moves one cell
// per clock; each cell compares it with its own entry, so the next item
// can be taken only once the token has left the last cell and the result
// has left the done state. Clear items and the unused function code go
// straight from idle to the done state. One item is in work at a time; a
// finished result waits in the output register while the next item is
// taken. New colors are appended in order of first appearance; once the
// palette is full, new colors are dropped and the sticky overflow flag is
// set until the next clear.
module rgb_palette_builder
    import rpb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pix_valid,
    output logic         pix_ready,
    input  wire rpb_in_t pix_data,
    output logic         res_valid,
    input  wire logic    res_ready,
    output rpb_out_t     res_data
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    rpb_out_t         result_reg;
    rpb_out_t         result_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    rpb_out_t         res_data_reg;
    rpb_out_t         res_data_next;
    wr_t              wr;
    tok_t             tok_head;
    tok_t             tok_chain [PALETTE_DEPTH+1];
    tok_t             tok_last;
    logic             full;

    assign full = count_reg == CNT_W'(PALETTE_DEPTH);
    assign tok_last = tok_chain[PALETTE_DEPTH];
    assign tok_chain[0] = tok_head;

    always_comb
    begin
        tok_head.valid      = pix_valid && pix_ready &&
                              (pix_data.func == FUNC_PIXEL ||
                               pix_data.func == FUNC_READ);
        tok_head.is_read    = pix_data.func == FUNC_READ;
        tok_head.color      = {pix_data.red, pix_data.green, pix_data.blue};
        tok_head.read_index = pix_data.read_index;
        tok_head.hit        = 1'b0;
        tok_head.hit_index  = '0;
        tok_head.rd_color   = '0;
    end

    for (genvar k = 0; k < PALETTE_DEPTH; k++)
    begin : g_cell
        rpb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(k)),
            .count      (count_reg),
            .wr         (wr),
            .tok_in     (tok_chain[k]),
            .tok_out    (tok_chain[k+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        result_next    = result_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;
        pix_ready      = 1'b0;
        wr.en          = 1'b0;
        wr.index       = IDX_W'(count_reg);
        wr.color       = tok_last.color;

        unique case (state_reg)
            ST_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    if (pix_data.func == FUNC_PIXEL || pix_data.func == FUNC_READ)
                    begin
                        state_next = ST_BUSY;
                    end
                    else
                    begin
                        if (pix_data.func == FUNC_CLEAR)
                        begin
                            count_next = '0;
                            ovf_next = 1'b0;
                        end
                        result_next = '0;
                        result_next.overflow = ovf_next;
                        result_next.palette_count = 9'(count_next);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BUSY:
            begin
                if (tok_last.valid)
                begin
                    result_next = '0;
                    if (tok_last.is_read)
                    begin
                        result_next.entry_red   = tok_last.rd_color[23:16];
                        result_next.entry_green = tok_last.rd_color[15:8];
                        result_next.entry_blue  = tok_last.rd_color[7:0];
                    end
                    else if (tok_last.hit)
                    begin
                        result_next.entry_index = 8'(tok_last.hit_index);
                    end
                    else if (!full)
                    begin
                        wr.en = 1'b1;
                        count_next = count_reg + 1'b1;
                        result_next.entry_index = 8'(count_reg);
                        result_next.was_new = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    result_next.overflow = ovf_next;
                    result_next.palette_count = 9'(count_next);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_data_next = result_reg;
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The count can never pass the palette depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PALETTE_DEPTH))
        else $error("palette count beyond depth");

    // A token leaves the row only while an item is in work.
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.valid |-> state_reg == ST_BUSY)
        else $error("token left the cell row while not busy");

    // Overflow is raised only when the palette was already full.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(full))
        else $error("overflow set with room left in the palette");

    // A new entry is written only into free space.
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !full)
        else $error("palette write while full");

endmodule

`default_nettype wire

// ===== verif/tb_rgb_palette_builder.sv =====
`timescale 1ns / 1ps
// Testbench for rgb_palette_builder: a directed table, then random image-like
// pixel streams with one full-palette fill, checked against a palette predictor.
// Depends on rpb_pkg and the rgb_palette_builder RTL.
module tb_rgb_palette_builder;
    import rpb_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        rpb_in_t  item;
        bit       fixed;
        rpb_out_t want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     pix_valid;
    logic     pix_ready;
    rpb_in_t  pix_data;
    logic     res_valid;
    logic     res_ready;
    rpb_out_t res_data;

    stim_row_t stim_q[$];
    rpb_out_t  expected_q[$];
    rpb_out_t  want_res;
    int        errors = 0;
    bit        stim_done = 1'b0;

    // Predictor copy of the palette.
    logic [23:0] pal_colors [PALETTE_DEPTH];
    int unsigned pal_count;
    logic        pal_overflow;

    // Shadow of the palette used while generating stimulus.
    bit          gen_seen [logic [23:0]];
    logic [23:0] gen_colors[$];

    rgb_palette_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    function automatic rpb_out_t palette_step(rpb_in_t it);
        rpb_out_t    r;
        logic [23:0] color;
        bit          hit;
        int unsigned where;
        r = '0;
        color = {it.red, it.green, it.blue};
        hit = 1'b0;
        where = 0;
        case (it.func)
            FUNC_CLEAR:
            begin
                pal_count = 0;
                pal_overflow = 1'b0;
            end
            FUNC_PIXEL:
            begin
                for (int k = 0; k < pal_count && !hit; k++)
                begin
                    if (pal_colors[IDX_W'(k)] == color)
                    begin
                        hit = 1'b1;
                        where = k;
                    end
                end
                if (hit)
                    r.entry_index = 8'(where);
                else if (pal_count < PALETTE_DEPTH)
                begin
                    pal_colors[IDX_W'(pal_count)] = color;
                    r.entry_index = 8'(pal_count);
                    r.was_new = 1'b1;
                    pal_count++;
                end
                else
                    pal_overflow = 1'b1;
            end
            FUNC_READ:
            begin
                // Entries at or above the count read back as black.
                if (it.read_index < pal_count)
                    {r.entry_red, r.entry_green, r.entry_blue} =
                        pal_colors[IDX_W'(it.read_index)];
            end
            default:
            begin
            end
        endcase
        r.overflow = pal_overflow;
        r.palette_count = 9'(pal_count);
        return r;
    endfunction

    function automatic rpb_in_t make_item(logic [1:0] f, logic [23:0] color, logic [7:0] idx);
        rpb_in_t it;
        it.func = f;
        {it.red, it.green, it.blue} = color;
        it.read_index = idx;
        return it;
    endfunction

    function automatic rpb_out_t status_of(logic [7:0] idx, logic nw, logic ov,
                                           logic [8:0] cnt, logic [23:0] color);
        rpb_out_t r;
        r.entry_index = idx;
        r.was_new = nw;
        r.overflow = ov;
        r.palette_count = cnt;
        {r.entry_red, r.entry_green, r.entry_blue} = color;
        return r;
    endfunction

    function automatic void add_row(rpb_in_t it, bit fixed, rpb_out_t want);
        stim_row_t row;
        row.item = it;
        row.fixed = fixed;
        row.want = want;
        stim_q.push_back(row);
    endfunction

    function automatic void gen_push(rpb_in_t it);
        logic [23:0] c;
        c = {it.red, it.green, it.blue};
        if (it.func == FUNC_CLEAR)
        begin
            gen_seen.delete();
            gen_colors.delete();
        end
        else if (it.func == FUNC_PIXEL && !gen_seen.exists(c) &&
                 gen_colors.size() < PALETTE_DEPTH)
        begin
            gen_seen[c] = 1'b1;
            gen_colors.push_back(c);
        end
        add_row(it, 1'b0, '0);
    endfunction

    function automatic logic [23:0] fresh_color();
        logic [23:0] c;
        do
            c = 24'($urandom);
        while (gen_seen.exists(c));
        return c;
    endfunction

    function automatic logic [23:0] known_color();
        return gen_colors[$urandom_range(0, gen_colors.size() - 1)];
    endfunction

    function automatic logic [7:0] pick_read_index();
        int unsigned n;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        n = $urandom_range(0, gen_colors.size());
        return (n > 255) ? 8'd255 : 8'(n);
    endfunction

    // Short image: hits, near misses, new colors, reads, unused codes and the odd clear.
    function automatic void gen_mixed_phase(int n);
        int sel;
        gen_push(make_item(FUNC_CLEAR, 24'($urandom), 8'($urandom)));
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35 && gen_colors.size() > 0)
                gen_push(make_item(FUNC_PIXEL, known_color(), 8'($urandom)));
            else if (sel < 45 && gen_colors.size() > 0)
                gen_push(make_item(FUNC_PIXEL, known_color() ^ (24'd1 << $urandom_range(0, 23)),
                                   8'($urandom)));
            else if (sel < 65)
                gen_push(make_item(FUNC_PIXEL, fresh_color(), 8'($urandom)));
            else if (sel < 88)
                gen_push(make_item(FUNC_READ, 24'($urandom), pick_read_index()));
            else if (sel < 95)
                gen_push(make_item(FUNC_UNUSED, 24'($urandom), 8'($urandom)));
            else
                gen_push(make_item(FUNC_CLEAR, 24'($urandom), 8'($urandom)));
        end
    endfunction

    // Fill the palette to the top, then push new colors past it among hits, reads and unused codes.
    function automatic void gen_fill_phase();
        int sel;
        gen_push(make_item(FUNC_CLEAR, 24'($urandom), 8'($urandom)));
        while (gen_colors.size() < PALETTE_DEPTH)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 86 || gen_colors.size() == 0)
                gen_push(make_item(FUNC_PIXEL, fresh_color(), 8'($urandom)));
            else if (sel < 94)
                gen_push(make_item(FUNC_PIXEL, known_color(), 8'($urandom)));
            else
                gen_push(make_item(FUNC_READ, 24'($urandom), pick_read_index()));
        end
        gen_push(make_item(FUNC_READ, 24'($urandom), 8'd255));
        gen_push(make_item(FUNC_PIXEL, gen_colors[PALETTE_DEPTH - 1], 8'($urandom)));
        repeat (16)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                gen_push(make_item(FUNC_PIXEL, fresh_color(), 8'($urandom)));
            else if (sel < 60)
                gen_push(make_item(FUNC_PIXEL, known_color(), 8'($urandom)));
            else if (sel < 85)
                gen_push(make_item(FUNC_READ, 24'($urandom), 8'($urandom)));
            else
                gen_push(make_item(FUNC_UNUSED, 24'($urandom), 8'($urandom)));
        end
    endfunction

    function automatic void build_stimulus();
        // Directed table; rows with a typed status are simple enough to work out by hand.
        add_row(make_item(FUNC_READ, 24'h000000, 8'd0), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd0, 24'h000000));
        add_row(make_item(FUNC_UNUSED, 24'hFFFFFF, 8'hFF), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd0, 24'h000000));
        add_row(make_item(FUNC_CLEAR, 24'hFFFFFF, 8'hFF), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd0, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'h000000, 8'hFF), 1'b1,
                status_of(8'd0, 1'b1, 1'b0, 9'd1, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'hFFFFFF, 8'h00), 1'b1,
                status_of(8'd1, 1'b1, 1'b0, 9'd2, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'h000000, 8'h00), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd2, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'hFF0000, 8'h00), 1'b0, '0);
        add_row(make_item(FUNC_PIXEL, 24'h00FF00, 8'h00), 1'b0, '0);
        add_row(make_item(FUNC_PIXEL, 24'h0000FF, 8'h00), 1'b0, '0);
        add_row(make_item(FUNC_READ, 24'h000000, 8'd1), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd5, 24'hFFFFFF));
        add_row(make_item(FUNC_READ, 24'hFFFFFF, 8'd4), 1'b0, '0);
        add_row(make_item(FUNC_READ, 24'h000000, 8'd5), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd5, 24'h000000));
        add_row(make_item(FUNC_READ, 24'h000000, 8'd255), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd5, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'h0000FF, 8'h00), 1'b0, '0);
        add_row(make_item(FUNC_UNUSED, 24'h123456, 8'h78), 1'b0, '0);
        add_row(make_item(FUNC_CLEAR, 24'h000000, 8'h00), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd0, 24'h000000));
        add_row(make_item(FUNC_READ, 24'h000000, 8'd0), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd0, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'hA55AC3, 8'h00), 1'b1,
                status_of(8'd0, 1'b1, 1'b0, 9'd1, 24'h000000));
        add_row(make_item(FUNC_PIXEL, 24'h000000, 8'h00), 1'b0, '0);
        add_row(make_item(FUNC_READ, 24'h000000, 8'd0), 1'b1,
                status_of(8'd0, 1'b0, 1'b0, 9'd2, 24'hA55AC3));

        gen_mixed_phase(52);
        gen_fill_phase();
        repeat (3)
            gen_mixed_phase(52);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Sender: bursts of transfers with random gaps, now and then a long one.
    initial
    begin : pixel_sender
        int        burst_left;
        int        gap;
        stim_row_t row;
        rpb_out_t  predicted;
        pix_valid = 1'b0;
        pix_data = '0;
        pal_count = 0;
        pal_overflow = 1'b0;
        build_stimulus();
        wait (rst_n === 1'b1);
        @(negedge clk);
        burst_left = 0;
        while (stim_q.size() > 0)
        begin
            row = stim_q.pop_front();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300)
                                                   : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    pix_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            pix_valid <= 1'b1;
            pix_data <= row.item;
            @(posedge clk);
            while (!pix_ready)
                @(posedge clk);
            predicted = palette_step(row.item);
            expected_q.push_back(row.fixed ? row.want : predicted);
            @(negedge clk);
        end
        pix_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: each stretch picks its own stall pattern.
    initial
    begin : result_receiver
        int          mode;
        int unsigned ready_cyc;
        res_ready = 1'b0;
        ready_cyc = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(50, 800))
            begin
                @(negedge clk);
                ready_cyc++;
                case (mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= ($urandom_range(0, 3) != 0);
                    2: res_ready <= ($urandom_range(0, 3) == 0);
                    default: res_ready <= ((ready_cyc % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no pending expectation");
                errors++;
            end
            else
            begin
                want_res = expected_q.pop_front();
                check_field("entry_index", 32'(want_res.entry_index),
                            32'(res_data.entry_index));
                check_field("was_new", 32'(want_res.was_new), 32'(res_data.was_new));
                check_field("overflow", 32'(want_res.overflow), 32'(res_data.overflow));
                check_field("palette_count", 32'(want_res.palette_count),
                            32'(res_data.palette_count));
                check_field("entry_red", 32'(want_res.entry_red), 32'(res_data.entry_red));
                check_field("entry_green", 32'(want_res.entry_green),
                            32'(res_data.entry_green));
                check_field("entry_blue", 32'(want_res.entry_blue), 32'(res_data.entry_blue));
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_q.size() == 0);
        // Let a full token walk pass so any stray result shows up.
        repeat (PALETTE_DEPTH + 8) @(posedge clk);
        if (errors == 0)
            $display("tb_rgb_palette_builder: PASS");
        else
            $display("tb_rgb_palette_builder: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_rgb_palette_builder: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpb_pkg.sv
rtl/rpb_cell.sv
rtl/rgb_palette_builder.sv
verif/tb_rgb_palette_builder.sv
